### sv/ifn_pkg.sv
`timescale 1ns / 1ps

package ifn_pkg;

  localparam int NEURON_W    = 11;
  localparam int WEIGHT_W    = 8;
  localparam int MEMBRANE_W  = 16;
  // Weights carry this many fraction bits; 1.0 is the firing threshold.
  localparam int FRAC_BITS   = 8;
  localparam int NEURONS_DEF = 2048;
  localparam int QUEUE_DEPTH = 4;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  localparam logic [MEMBRANE_W-1:0] THRESHOLD = MEMBRANE_W'(1 << FRAC_BITS);

  typedef enum logic {
    OP_SYNAPSE = 1'b0,
    OP_LOAD    = 1'b1
  } op_e;

  // One classified transaction handed from the front to the back.
  typedef struct packed {
    op_e                   op;
    logic                  first;
    logic                  last;
    logic                  spike;
    logic                  in_range;
    logic [NEURON_W-1:0]   idx;
    logic [WEIGHT_W-1:0]   weight;
    logic [MEMBRANE_W-1:0] load_value;
  } cmd_t;

endpackage

### sv/integrate_fire_neuron_fixed_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Signals                          Transaction
// s_axis   in   tvalid tready tdata tuser tlast  synapse item or membrane load
// m_axis   out  tvalid tready tdata              finished neuron update
//
// One input transaction is taken per cycle while the queue has room and the
// reset sweep is done; the store is a single RAM with one write and one
// registered read per cycle, and a write that collides with a read is
// forwarded. A result's last item passes through the queue and the execute
// stage, and tvalid rises from the output register behind them. After reset
// the input side stays not ready while the membrane store is swept to zero. A
// stalled output fills the four-entry queue before the input side drops tready.

module integrate_fire_neuron_fixed_unit
  import ifn_pkg::*;
#(
  parameter int NEURONS = NEURONS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // neuron[10:0], spike[11], weight[19:12], load_value[35:20], zero[39:36]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation[0]
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_neuron[10:0], fired[11], membrane[27:12], zero[31:28]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                  accept;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic                  clear_busy;
  cmd_t                  push_cmd;
  cmd_t                  pop_cmd;
  logic [NEURON_W-1:0]   out_neuron;
  logic                  out_fired;
  logic [MEMBRANE_W-1:0] out_membrane;

  assign s_axis_tready = !q_full && !clear_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ifn_front #(
    .NEURONS (NEURONS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (op_e'(s_axis_tuser)),
    .neuron_i     (s_axis_tdata[10:0]),
    .spike_i      (s_axis_tdata[11]),
    .weight_i     (s_axis_tdata[19:12]),
    .last_i       (s_axis_tlast),
    .load_value_i (s_axis_tdata[35:20]),
    .cmd_o        (push_cmd)
  );

  ifn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  ifn_back #(
    .NEURONS (NEURONS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_cmd_i        (pop_cmd),
    .q_pop_o        (q_pop),
    .clear_busy_o   (clear_busy),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_neuron_o   (out_neuron),
    .out_fired_o    (out_fired),
    .out_membrane_o (out_membrane)
  );

  assign m_axis_tdata = {4'b0000, out_membrane, out_fired, out_neuron};

endmodule

### sv/ifn_ram.sv
`timescale 1ns / 1ps

module ifn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read in the cycle of a write to the same address returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ifn_front.sv
`timescale 1ns / 1ps

module ifn_front
  import ifn_pkg::*;
#(
  parameter int NEURONS = NEURONS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  op_e                   op_i,
  input  logic [NEURON_W-1:0]   neuron_i,
  input  logic                  spike_i,
  input  logic [WEIGHT_W-1:0]   weight_i,
  input  logic                  last_i,
  input  logic [MEMBRANE_W-1:0] load_value_i,
  output cmd_t                  cmd_o
);

  logic                run_active_q, run_active_d;
  logic [NEURON_W-1:0] run_neuron_q, run_neuron_d;
  logic [NEURON_W-1:0] idx;
  logic                is_load;

  assign is_load = (op_i == OP_LOAD);

  // While a run is active its latched neuron addresses every synapse item.
  assign idx = (!is_load && run_active_q) ? run_neuron_q : neuron_i;

  always_comb begin
    cmd_o.op         = op_i;
    cmd_o.first      = !is_load && !run_active_q;
    cmd_o.last       = last_i;
    cmd_o.spike      = spike_i;
    cmd_o.idx        = idx;
    cmd_o.weight     = weight_i;
    cmd_o.load_value = load_value_i;
    if (NEURONS >= (1 << NEURON_W)) begin
      cmd_o.in_range = 1'b1;
    end else begin
      cmd_o.in_range = (idx < NEURON_W'(NEURONS));
    end
  end

  always_comb begin
    run_active_d = run_active_q;
    run_neuron_d = run_neuron_q;
    if (accept_i && !is_load) begin
      if (!run_active_q) begin
        run_neuron_d = neuron_i;
      end
      run_active_d = !last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q <= 1'b0;
      run_neuron_q <= '0;
    end else begin
      run_active_q <= run_active_d;
      run_neuron_q <= run_neuron_d;
    end
  end

endmodule

### sv/ifn_queue.sv
`timescale 1ns / 1ps

module ifn_queue
  import ifn_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_cmd_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          store_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o    = (count_q == CW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### sv/ifn_back.sv
`timescale 1ns / 1ps

module ifn_back
  import ifn_pkg::*;
#(
  parameter int NEURONS = NEURONS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  cmd_t                  q_cmd_i,
  output logic                  q_pop_o,
  output logic                  clear_busy_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NEURON_W-1:0]   out_neuron_o,
  output logic                  out_fired_o,
  output logic [MEMBRANE_W-1:0] out_membrane_o
);

  localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  logic                  clear_busy_q;
  logic [AW-1:0]         clear_addr_q;

  logic                  s2_valid_q;
  cmd_t                  s2_cmd_q;
  logic                  byp_hit_q;
  logic [MEMBRANE_W-1:0] byp_data_q;
  logic [MEMBRANE_W-1:0] sum_q;

  logic                  out_valid_q;
  logic [NEURON_W-1:0]   out_neuron_q;
  logic                  out_fired_q;
  logic [MEMBRANE_W-1:0] out_membrane_q;

  logic [MEMBRANE_W-1:0] ram_rdata;
  logic [MEMBRANE_W-1:0] base;
  logic [MEMBRANE_W-1:0] acc_in;
  logic [MEMBRANE_W-1:0] addend;
  logic [MEMBRANE_W-1:0] sum_new;
  logic                  fire;
  logic [MEMBRANE_W-1:0] new_mem;
  logic                  s2_load;
  logic                  needs_out;
  logic                  s2_go;
  logic                  s2_wr;
  logic                  pop;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [MEMBRANE_W-1:0] wdata;
  logic [AW-1:0]         raddr;

  assign s2_load = (s2_cmd_q.op == OP_LOAD);

  // The first item of a run starts from the stored membrane; a write that
  // landed in the cycle of its read is forwarded from the bypass register.
  assign base    = !s2_cmd_q.in_range ? '0 :
                   byp_hit_q          ? byp_data_q : ram_rdata;
  assign acc_in  = s2_cmd_q.first ? base : sum_q;
  assign addend  = s2_cmd_q.spike ?
                   MEMBRANE_W'(signed'(s2_cmd_q.weight)) : '0;
  assign sum_new = acc_in + addend;
  assign fire    = ($signed(sum_new) >= $signed(THRESHOLD));
  assign new_mem = fire ? '0 : sum_new;

  assign needs_out = s2_valid_q && !s2_load && s2_cmd_q.last;
  assign s2_go     = s2_valid_q && (!needs_out || !out_valid_q || out_ready_i);
  assign pop       = !q_empty_i && !clear_busy_q && (!s2_valid_q || s2_go);
  assign q_pop_o   = pop;

  assign s2_wr = s2_go && s2_cmd_q.in_range && (s2_load || s2_cmd_q.last);
  assign we    = clear_busy_q || s2_wr;
  assign waddr = clear_busy_q ? clear_addr_q : AW'(s2_cmd_q.idx);
  assign wdata = clear_busy_q ? '0 :
                 s2_load      ? s2_cmd_q.load_value : new_mem;
  assign raddr = AW'(q_cmd_i.idx);

  ifn_ram #(
    .WIDTH (MEMBRANE_W),
    .DEPTH (NEURONS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (pop),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Reset sweep: every membrane entry is written with zero, one per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_busy_q <= 1'b1;
      clear_addr_q <= '0;
    end else if (clear_busy_q) begin
      clear_addr_q <= clear_addr_q + 1'b1;
      if (clear_addr_q == AW'(NEURONS - 1)) begin
        clear_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      if (pop) begin
        s2_valid_q <= 1'b1;
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_go && !s2_load) begin
        sum_q <= s2_cmd_q.last ? '0 : sum_new;
      end
      if (s2_go && needs_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s2_cmd_q   <= q_cmd_i;
      byp_hit_q  <= we && (waddr == raddr);
      byp_data_q <= wdata;
    end
    if (s2_go && needs_out) begin
      out_neuron_q   <= s2_cmd_q.idx;
      out_fired_q    <= fire;
      out_membrane_q <= new_mem;
    end
  end

  assign clear_busy_o   = clear_busy_q;
  assign out_valid_o    = out_valid_q;
  assign out_neuron_o   = out_neuron_q;
  assign out_fired_o    = out_fired_q;
  assign out_membrane_o = out_membrane_q;

endmodule

### tb/tb_integrate_fire_neuron_fixed_unit.sv
`timescale 1ns / 1ps

module tb_integrate_fire_neuron_fixed_unit;
  import ifn_pkg::*;

  typedef struct {
    logic [NEURON_W-1:0]   neuron;
    logic                  fired;
    logic [MEMBRANE_W-1:0] membrane;
  } nrn_update_t;

  // Tracks every membrane and the open run, and queues the neuron updates
  // that the block owes us.
  class membrane_tracker;
    logic [MEMBRANE_W-1:0] stored [NEURONS_DEF];
    logic [MEMBRANE_W-1:0] acc;
    logic                  run_open;
    logic [NEURON_W-1:0]   run_idx;
    nrn_update_t           pending_updates[$];
    int                    failures;

    function new();
      foreach (stored[i]) stored[i] = '0;
      acc = '0;
      run_open = 1'b0;
      run_idx = '0;
      failures = 0;
    endfunction

    function void note_item(op_e op, logic [NEURON_W-1:0] nrn, logic spk,
                            logic [WEIGHT_W-1:0] w, logic lst,
                            logic [MEMBRANE_W-1:0] lv);
      nrn_update_t upd;
      if (op == OP_LOAD) begin
        stored[nrn] = lv;
        return;
      end
      // The neuron field only counts on the first item of a run.
      if (!run_open) begin
        run_open = 1'b1;
        run_idx = nrn;
        acc = stored[nrn];
      end
      if (spk) begin
        acc = acc + {{(MEMBRANE_W-WEIGHT_W){w[WEIGHT_W-1]}}, w};
      end
      if (lst) begin
        upd.neuron = run_idx;
        upd.fired = ($signed(acc) >= $signed(THRESHOLD));
        upd.membrane = upd.fired ? '0 : acc;
        stored[run_idx] = upd.membrane;
        pending_updates.push_back(upd);
        run_open = 1'b0;
        acc = '0;
      end
    endfunction

    function void check_update(logic [OUT_TDATA_W-1:0] td);
      nrn_update_t           want;
      logic [NEURON_W-1:0]   got_n;
      logic                  got_f;
      logic [MEMBRANE_W-1:0] got_m;
      got_n = td[NEURON_W-1:0];
      got_f = td[NEURON_W];
      got_m = td[NEURON_W+1 +: MEMBRANE_W];
      if (pending_updates.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected update: neuron %0d fired %0b membrane %h",
                   got_n, got_f, got_m);
        end
        return;
      end
      want = pending_updates.pop_front();
      if (got_n !== want.neuron || got_f !== want.fired ||
          got_m !== want.membrane) begin
        failures++;
        if (failures <= 10) begin
          $display("update mismatch: expected neuron %0d fired %0b membrane %h,",
                   want.neuron, want.fired, want.membrane);
          $display("  got neuron %0d fired %0b membrane %h",
                   got_n, got_f, got_m);
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  membrane_tracker sb;
  int  items_sent;
  int  hold_left;
  bit  steady;

  integrate_fire_neuron_fixed_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #400000;
    $display("tb_integrate_fire_neuron_fixed_unit NOT OK");
    $finish;
  end

  // Receiver: random stalls, a steady stretch, and a long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 38);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_update(m_axis_tdata);
    end
  end

  task automatic send_item(op_e op, logic [NEURON_W-1:0] nrn, logic spk,
                           logic [WEIGHT_W-1:0] w, logic lst,
                           logic [MEMBRANE_W-1:0] lv);
    while (!steady && $urandom_range(99) < 38) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({lv, w, spk, nrn});
    s_axis_tuser  <= op;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, nrn, spk, w, lst, lv);
    items_sent++;
  endtask

  task automatic send_load(logic [NEURON_W-1:0] nrn, logic [MEMBRANE_W-1:0] lv);
    send_item(OP_LOAD, nrn, logic'($urandom_range(1)), WEIGHT_W'($urandom), 1'b0, lv);
  endtask

  task automatic send_syn(logic [NEURON_W-1:0] nrn, logic spk,
                          logic [WEIGHT_W-1:0] w, logic lst);
    send_item(OP_SYNAPSE, nrn, spk, w, lst, MEMBRANE_W'($urandom));
  endtask

  // Whole runs with random content, loads sprinkled before and inside them.
  task automatic random_runs(int n);
    int                    stop;
    int                    len;
    logic [NEURON_W-1:0]   nrn;
    logic [MEMBRANE_W-1:0] lv;
    logic [WEIGHT_W-1:0]   w;
    stop = items_sent + n;
    while (items_sent < stop) begin
      nrn = ($urandom_range(99) < 70) ? NEURON_W'($urandom_range(15))
                                      : NEURON_W'($urandom_range(2047));
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      if ($urandom_range(99) < 10) begin
        lv = ($urandom_range(1) == 1) ? MEMBRANE_W'($urandom)
                                      : MEMBRANE_W'($urandom_range(200, 300));
        send_load(nrn, lv);
      end
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < 6) begin
          send_load(($urandom_range(1) == 1) ? nrn : NEURON_W'($urandom_range(2047)),
                    MEMBRANE_W'($urandom));
        end
        w = ($urandom_range(1) == 1) ? WEIGHT_W'($urandom) : WEIGHT_W'($urandom_range(127));
        send_syn((k == 0) ? nrn : NEURON_W'($urandom_range(2047)),
                 logic'($urandom_range(99) < 75), w, logic'(k == len - 1));
      end
    end
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    hold_left = 0;
    steady = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_SYNAPSE;
    s_axis_tlast = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Extremes with wraparound in both directions.
    send_load(11'd0, 16'h7FFF);
    send_load(11'd2047, 16'h8000);
    send_syn(11'd2047, 1'b1, 8'h80, 1'b1);
    send_syn(11'd0, 1'b1, 8'h7F, 1'b1);
    // Neuron field changes mid-run; the run ends on an item without a spike.
    send_syn(11'd5, 1'b1, 8'h7F, 1'b0);
    send_syn(11'd9, 1'b1, 8'h7F, 1'b0);
    send_syn(11'd9, 1'b0, 8'h55, 1'b1);
    // Sums just at and just below the threshold.
    send_syn(11'd6, 1'b1, 8'h7F, 1'b0);
    send_syn(11'd6, 1'b1, 8'h7F, 1'b0);
    send_syn(11'd6, 1'b1, 8'h02, 1'b1);
    send_syn(11'd7, 1'b1, 8'h7F, 1'b0);
    send_syn(11'd7, 1'b1, 8'h7F, 1'b0);
    send_syn(11'd7, 1'b1, 8'h01, 1'b1);
    // Loads during a run, one of them to the running neuron.
    send_syn(11'd7, 1'b1, 8'h01, 1'b0);
    send_load(11'd7, 16'h1234);
    send_load(11'd8, 16'hFFFB);
    send_syn(11'd3, 1'b0, 8'h10, 1'b1);
    send_syn(11'd8, 1'b1, 8'h80, 1'b1);
    send_load(11'd3, 16'h0100);
    send_syn(11'd3, 1'b0, 8'h00, 1'b1);
    send_load(11'd4, 16'h00FF);
    send_syn(11'd4, 1'b0, 8'hFF, 1'b1);
    send_load(11'd2047, 16'h0000);

    random_runs(400);

    steady = 1'b1;
    random_runs(200);
    steady = 1'b0;

    // Stall the output long enough that the block backs up into its input.
    hold_left = 300;
    for (int i = 0; i < 40; i++) begin
      send_syn(NEURON_W'($urandom_range(2047)), logic'($urandom_range(1)),
               WEIGHT_W'($urandom), 1'b1);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_updates.size() != 0) @(posedge clk_i);

    random_runs(510);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_updates.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending_updates.size() == 0) begin
      $display("tb_integrate_fire_neuron_fixed_unit OK");
    end else begin
      $display("tb_integrate_fire_neuron_fixed_unit NOT OK");
    end
    $finish;
  end

endmodule
